### hdl/iplpr_pkg.sv
`timescale 1ns / 1ps

package iplpr_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned IFC_W  = 2;
  localparam int unsigned TTL_W  = 8;
  localparam int unsigned STAT_W = 3;

  // Longest prefix the table stores; longer lengths clamp to it
  localparam logic [LEN_W-1:0] MAX_PREFIX_LEN = LEN_W'(ADDR_W);
  localparam logic [TTL_W-1:0] TTL_MIN_FWD    = TTL_W'(2);

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_ROUTE = 1'b1
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_FORWARD  = 3'd0,
    STAT_NO_ROUTE = 3'd1,
    STAT_TTL_EXP  = 3'd2,
    STAT_ADDED    = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  net_prefix;
    logic [LEN_W-1:0]   prefix_len;
    logic               has_next_hop;
    logic [ADDR_W-1:0]  next_hop_ip;
    logic [IFC_W-1:0]   interface_index;
    logic [ADDR_W-1:0]  dst_addr;
    logic [TTL_W-1:0]   ttl_in;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [IFC_W-1:0]   out_interface;
    logic [ADDR_W-1:0]  hop_addr;
    logic [TTL_W-1:0]   ttl_out;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   len;
    logic               has_gw;
    logic [ADDR_W-1:0]  gateway;
    logic [IFC_W-1:0]   ifc;
  } route_t;

endpackage

### hdl/ipv4_longest_prefix_router_unit.sv
`timescale 1ns / 1ps

// IPv4 longest-prefix-match routing table.
// Command port: a beat on req_i is taken at a clock edge where start is high
// and busy is low. kind selects add (append a route) or route (look up dst_addr).
// Result port: rsp_o is valid for exactly one cycle while rsp_valid_o is high;
// the receiver cannot stall it and must take it in that cycle.
// Add: the route is written into the table memory at the accept edge and the
// result (added, or table full) appears in the next cycle; busy stays low.
// Route: the stored routes are read one per cycle from the table memory and
// fed to one prefix compare unit that keeps the best match so far.
// Busy is high from the accept edge until the result is shown, and the next
// command is taken in the cycle the result is shown.
// Reset clears the route count and all control state; the table contents are
// not cleared, only entries below the count are ever read.
// Longest prefix wins, on equal length the earliest added route wins.
module ipv4_longest_prefix_router_unit #(
  parameter int unsigned ROUTE_ENTRIES  = 16,
  parameter int unsigned NUM_INTERFACES = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  iplpr_pkg::req_t req_i,
  output logic            rsp_valid_o,
  output iplpr_pkg::rsp_t rsp_o
);

  localparam int unsigned IDX_W = $clog2(ROUTE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ROUTE_ENTRIES);
  localparam logic [4:0] NIF = 5'(NUM_INTERFACES);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_DONE   = 3'b100
  } state_e;

  state_e state_q, state_d;

  iplpr_pkg::route_t table_mem [ROUTE_ENTRIES];
  iplpr_pkg::route_t rd_q;
  iplpr_pkg::route_t best_q, best_d;
  iplpr_pkg::route_t new_route;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             found_q, found_d;
  logic [iplpr_pkg::ADDR_W-1:0] dst_q;
  logic [iplpr_pkg::TTL_W-1:0]  ttl_q;

  logic             rsp_valid_q, rsp_valid_d;
  iplpr_pkg::rsp_t  rsp_q, rsp_d;

  logic             accept;
  logic             wr_en;
  logic             rd_en;
  logic             hit;
  logic [iplpr_pkg::ADDR_W-1:0] mask;
  logic [4:0]       ifc_wide;
  logic [iplpr_pkg::IFC_W-1:0]  ifc_red;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // Reduce the interface index into the configured interface range
  always_comb begin
    ifc_wide = {3'b000, req_i.interface_index};
    ifc_red  = req_i.interface_index;
    if (NUM_INTERFACES == 1) begin
      ifc_red = '0;
    end else if (ifc_wide >= NIF) begin
      ifc_red = iplpr_pkg::IFC_W'(ifc_wide - NIF);
    end
  end

  always_comb begin
    new_route.prefix  = req_i.net_prefix;
    new_route.len     = (req_i.prefix_len > iplpr_pkg::MAX_PREFIX_LEN) ?
                        iplpr_pkg::MAX_PREFIX_LEN : req_i.prefix_len;
    new_route.has_gw  = req_i.has_next_hop;
    new_route.gateway = req_i.has_next_hop ? req_i.next_hop_ip : '0;
    new_route.ifc     = ifc_red;
  end

  assign wr_en = accept && (req_i.kind == iplpr_pkg::KIND_ADD) && (cnt_q != CNT_FULL);
  assign rd_en = (state_q == ST_LOOKUP) && (idx_q != cnt_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[cnt_q[IDX_W-1:0]] <= new_route;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= table_mem[idx_q[IDX_W-1:0]];
    end
  end

  // Shared compare unit: masked prefix match against the entry read last cycle
  always_comb begin
    mask = ~({iplpr_pkg::ADDR_W{1'b1}} >> rd_q.len);
    hit  = (((rd_q.prefix ^ dst_q) & mask) == '0);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    found_d     = found_q;
    best_d      = best_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.kind == iplpr_pkg::KIND_ADD) begin
            rsp_valid_d          = 1'b1;
            rsp_d.out_interface  = '0;
            rsp_d.hop_addr       = '0;
            rsp_d.ttl_out        = '0;
            if (cnt_q == CNT_FULL) begin
              rsp_d.status = iplpr_pkg::STAT_FULL;
            end else begin
              rsp_d.status = iplpr_pkg::STAT_ADDED;
              cnt_d        = cnt_q + CNT_W'(1);
            end
          end else begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (rd_en) begin
          idx_d     = idx_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
        end
        if (cmp_vld_q && hit && (!found_q || (best_q.len < rd_q.len))) begin
          found_d = 1'b1;
          best_d  = rd_q;
        end
        if (!rd_en) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        rsp_valid_d         = 1'b1;
        rsp_d.out_interface = '0;
        rsp_d.hop_addr      = '0;
        rsp_d.ttl_out       = '0;
        if (!found_q) begin
          rsp_d.status = iplpr_pkg::STAT_NO_ROUTE;
        end else if (ttl_q < iplpr_pkg::TTL_MIN_FWD) begin
          rsp_d.status = iplpr_pkg::STAT_TTL_EXP;
        end else begin
          rsp_d.status        = iplpr_pkg::STAT_FORWARD;
          rsp_d.out_interface = best_q.ifc;
          rsp_d.hop_addr      = best_q.has_gw ? best_q.gateway : dst_q;
          rsp_d.ttl_out       = ttl_q - iplpr_pkg::TTL_W'(1);
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    rsp_q  <= rsp_d;
    if (accept) begin
      dst_q <= req_i.dst_addr;
      ttl_q <= req_i.ttl_in;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_route_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.kind == iplpr_pkg::KIND_ROUTE)) |=> busy)
    else $error("route beat did not start a lookup");

  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (rsp_valid_o && !busy))
    else $error("lookup finished without a result beat");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_FULL) && (idx_q <= cnt_q))
    else $error("route count or scan index out of range");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status != iplpr_pkg::STAT_FORWARD)) |->
    ((rsp_o.hop_addr == '0) && (rsp_o.ttl_out == '0) && (rsp_o.out_interface == '0)))
    else $error("non-forward result carries forwarding fields");

endmodule
